/* rtl/gwm_pkg.sv */
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int PATTERN_MAX = 63;
    localparam int POS_W       = $clog2(PATTERN_MAX + 1);
    localparam int VEC_W       = PATTERN_MAX + 1;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [VEC_W-1:0]  vec_t;

    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_BYTE = 2'd1;
    localparam op_t OP_END  = 2'd2;

    localparam char_t WILD_ONE = 8'h3F;
    localparam char_t WILD_ANY = 8'h2A;

    typedef struct packed {
        logic  en;
        logic  begin_pat;
        char_t data;
    } pat_wr_t;

    typedef struct packed {
        vec_t star_mask;
        vec_t hit_mask;
        pos_t length;
        logic overflow;
    } pat_info_t;

    typedef struct packed {
        logic advance;
        logic rearm;
    } match_ctl_t;

endpackage

/* rtl/wildcard_glob_matcher.sv */
`timescale 1ns / 1ps
// An end-of-subject item waits in the input register; its result is then registered.
// Throughput: one item per cycle, limited only by the result register being taken.
// Each item is held in the input register while the store or live set is updated.
// Reset (aresetn, synchronous, active low) clears the pattern length, the overflow flag
// and both valid flags; pattern store contents are undefined until loaded.

module wildcard_glob_matcher
    import gwm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  op_t   s_op,
    input  char_t s_char_value,
    input  logic  s_begin_pattern,
    output logic  m_valid,
    input  logic  m_ready,
    output logic  m_matched,
    output logic  m_pattern_overflow
);

    logic       s1_valid_reg;
    op_t        s1_op_reg;
    char_t      s1_char_reg;
    logic       s1_begin_reg;
    logic       m_valid_reg;
    logic       m_matched_reg;
    logic       m_overflow_reg;
    logic       out_free;
    logic       s1_fire;
    logic       proc_end;
    logic       matched;
    pat_wr_t    wr;
    pat_info_t  info;
    match_ctl_t ctl;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && ((s1_op_reg != OP_END) || out_free);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign proc_end = s1_fire && (s1_op_reg == OP_END);

    assign wr.en        = s1_fire && (s1_op_reg == OP_LOAD);
    assign wr.begin_pat = s1_begin_reg;
    assign wr.data      = s1_char_reg;

    assign ctl.advance = s1_fire && (s1_op_reg == OP_BYTE);
    assign ctl.rearm   = wr.en || proc_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_op_reg    <= s_op;
            s1_char_reg  <= s_char_value;
            s1_begin_reg <= s_begin_pattern;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_end) begin
            m_matched_reg  <= matched;
            m_overflow_reg <= info.overflow;
        end
    end

    gwm_pattern_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .subj_char (s1_char_reg),
        .info      (info)
    );

    gwm_match_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .info    (info),
        .ctl     (ctl),
        .matched (matched)
    );

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_overflow_reg;

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_end |=> m_valid_reg)
        else $error("End item processed without a result being presented.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && (s1_op_reg == OP_END) && m_valid_reg && !m_ready))
        else $error("Input stalled without a blocked result transfer.");

endmodule

/* rtl/gwm_pattern_store.sv */
`timescale 1ns / 1ps

module gwm_pattern_store
    import gwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pat_wr_t   wr,
    input  char_t     subj_char,
    output pat_info_t info
);

    char_t store_reg [PATTERN_MAX];
    pos_t  len_reg;
    pos_t  len_next;
    logic  ov_reg;
    logic  ov_next;
    pos_t  len_eff;
    logic  full;
    vec_t  star_mask;
    vec_t  hit_mask;

    assign len_eff  = wr.begin_pat ? '0 : len_reg;
    assign full     = (len_eff == pos_t'(PATTERN_MAX));
    assign len_next = full ? len_eff : len_eff + pos_t'(1);
    assign ov_next  = (wr.begin_pat ? 1'b0 : ov_reg) | full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ov_reg  <= 1'b0;
        end else if (wr.en) begin
            len_reg <= len_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && !full) begin
            store_reg[len_eff] <= wr.data;
        end
    end

    for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pos
        logic in_range;
        assign in_range     = (pos_t'(p) < len_reg);
        assign star_mask[p] = in_range && (store_reg[p] == WILD_ANY);
        assign hit_mask[p]  = in_range
                              && ((store_reg[p] == WILD_ONE) || (store_reg[p] == subj_char));
    end
    assign star_mask[VEC_W-1] = 1'b0;
    assign hit_mask[VEC_W-1]  = 1'b0;

    assign info.star_mask = star_mask;
    assign info.hit_mask  = hit_mask;
    assign info.length    = len_reg;
    assign info.overflow  = ov_reg;

    a_ov_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> (len_reg == pos_t'(PATTERN_MAX)))
        else $error("Overflow flag set with a pattern shorter than the store.");

    a_begin_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && wr.begin_pat) |=> (len_reg == pos_t'(1)))
        else $error("A new pattern did not restart at length one.");

endmodule

/* rtl/gwm_match_core.sv */
`timescale 1ns / 1ps

module gwm_match_core
    import gwm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pat_info_t  info,
    input  match_ctl_t ctl,
    output logic       matched
);

    vec_t raw_reg;
    vec_t raw_next;
    vec_t gen;
    vec_t sum;
    vec_t closure;
    vec_t adv;

    // The star closure is a carry chain: a live star generates, a run of stars propagates.
    assign gen     = raw_reg & info.star_mask;
    assign sum     = info.star_mask + gen;
    assign closure = raw_reg | (sum ^ info.star_mask ^ gen);

    assign adv = (closure & info.star_mask)
                 | ((closure & info.hit_mask & ~info.star_mask) << 1);

    assign matched = closure[info.length];

    always_comb begin
        priority if (ctl.rearm) begin
            raw_next = vec_t'(1);
        end else if (ctl.advance) begin
            raw_next = adv;
        end else begin
            raw_next = raw_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg <= vec_t'(1);
        end else begin
            raw_reg <= raw_next;
        end
    end

    a_live_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (raw_reg & ~((vec_t'(2) << info.length) - vec_t'(1))) == '0)
        else $error("Live position beyond the end of the pattern.");

endmodule
